[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the point-to-angle checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTBA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Implication with a fixed delay to the consequent, disabled during reset.
`define PTBA_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("delayed response check failed");

`endif

[rtl/core/ptba_pkg.sv]
// ----------------------------------------------------------------------------
// ptba_pkg
// Constants, types and the arctangent table builder for the point-to-angle unit.
// ----------------------------------------------------------------------------
package ptba_pkg;

    // Slope resolution: table covers atan(i / SLOPE_RANGE), i = 0..SLOPE_RANGE
    localparam int SLOPE_RANGE = 2048;
    localparam int IDX_W       = $clog2(SLOPE_RANGE + 1);
    localparam int QUO_W       = $clog2(SLOPE_RANGE);

    localparam int COORD_W     = 32;
    localparam int ANGLE_W     = 32;
    localparam int NUM_SHIFT   = 3;
    localparam int DEN_SHIFT   = 8;
    localparam int SMALL_DEN   = 512;
    localparam int DEN_W       = COORD_W - DEN_SHIFT;
    localparam int CMP_W       = DEN_W + IDX_W;

    // Cycles from an accepted start to the done strobe
    localparam int LATENCY     = QUO_W + 6;

    localparam int CORDIC_STEPS = 32;
    localparam int CORDIC_FRAC  = 40;

    typedef logic [ANGLE_W-1:0] angle_t;
    typedef angle_t rom_t [0:SLOPE_RANGE];
    typedef angle_t cordic_tab_t [0:CORDIC_STEPS-1];

    localparam angle_t ANG90  = 32'h4000_0000;
    localparam angle_t ANG180 = 32'h8000_0000;
    localparam angle_t ANG270 = 32'hC000_0000;
    localparam angle_t ANG_CLAMP = 32'h2000_0000;

    // Octant codes: {x negative, y negative, |x| > |y|}
    localparam logic [2:0] OCT_PX_PY_YSTEEP = 3'b000;
    localparam logic [2:0] OCT_PX_PY_XWIDE  = 3'b001;
    localparam logic [2:0] OCT_PX_NY_YSTEEP = 3'b010;
    localparam logic [2:0] OCT_PX_NY_XWIDE  = 3'b011;
    localparam logic [2:0] OCT_NX_PY_YSTEEP = 3'b100;
    localparam logic [2:0] OCT_NX_PY_XWIDE  = 3'b101;
    localparam logic [2:0] OCT_NX_NY_YSTEEP = 3'b110;
    localparam logic [2:0] OCT_NX_NY_XWIDE  = 3'b111;

    // Sideband that travels down the pipe with each beat
    typedef struct packed {
        logic zero;
        logic [2:0] oct;
        logic force_max;
    } meta_t;

    // atan(2^-k) in 2^32-per-turn units
    localparam cordic_tab_t CORDIC_ATAN = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // Arithmetic shift right that truncates toward zero
    function automatic longint shift_tz(longint v, int k);
        longint mag;
        if (v >= 0) begin
            return v >>> k;
        end
        mag = -v;
        return -(mag >>> k);
    endfunction

    // Vectoring CORDIC for one table entry, clamped to the first octant
    function automatic angle_t cordic_angle(int i);
        longint x;
        longint y;
        longint xs;
        longint ys;
        angle_t a;
        bit     run;
        x   = longint'(SLOPE_RANGE) <<< CORDIC_FRAC;
        y   = longint'(i) <<< CORDIC_FRAC;
        a   = '0;
        run = 1'b1;
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            if (y == 0) begin
                run = 1'b0;
            end
            if (run) begin
                xs = shift_tz(x, k);
                ys = shift_tz(y, k);
                if (y > 0) begin
                    x = x + ys;
                    y = y - xs;
                    a = a + CORDIC_ATAN[k];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    a = a - CORDIC_ATAN[k];
                end
            end
        end
        if (a[ANGLE_W-1]) begin
            return '0;
        end
        if (a > ANG_CLAMP) begin
            return ANG_CLAMP;
        end
        return a;
    endfunction

    // Full ROM image, evaluated at elaboration
    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i <= SLOPE_RANGE; i++) begin
            r[i] = cordic_angle(i);
        end
        return r;
    endfunction

endpackage

[rtl/core/point_to_binary_angle_unit.sv]
// ----------------------------------------------------------------------------
// point_to_binary_angle_unit
// Direction from one 16.16 point to another as a 32-bit binary angle.
// ----------------------------------------------------------------------------
// Usage:
//   Drive from_x/from_y/to_x/to_y and pulse start; a beat is taken at every
//   rising edge with start high and busy low. busy stays low, so a new beat
//   can enter on every cycle.
//   Each beat yields one angle on the angle port, marked by a one-cycle done
//   strobe. Results leave in the order their beats arrived.
//   The path runs through the difference, fold, select and saturation stages,
//   the slope divider with one restoring quotient bit per pipeline stage
//   (11 stages), the registered arctangent ROM read and the octant offset
//   stage. Throughput is one beat per cycle.
//   The arctangent table is a 2049-entry synchronous ROM whose image is
//   built at elaboration; it needs no fill pass after reset.
//   Reset clears all stage valid flags, so beats in flight are dropped and
//   done stays low until new beats reach the end. The receiver cannot stall:
//   a result not taken in its done cycle is gone.
// ----------------------------------------------------------------------------
module point_to_binary_angle_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [ptba_pkg::COORD_W-1:0] from_x,
    input  logic signed [ptba_pkg::COORD_W-1:0] from_y,
    input  logic signed [ptba_pkg::COORD_W-1:0] to_x,
    input  logic signed [ptba_pkg::COORD_W-1:0] to_y,
    output logic        done,
    output logic [ptba_pkg::ANGLE_W-1:0] angle
);

    localparam int QW = ptba_pkg::QUO_W;
    localparam int CW = ptba_pkg::CMP_W;
    localparam int NW = ptba_pkg::COORD_W;
    localparam int DW = ptba_pkg::DEN_W;
    localparam int IW = ptba_pkg::IDX_W;

    localparam ptba_pkg::rom_t ATAN_ROM = ptba_pkg::build_rom();

    logic accept;

    // Stage A: differences
    logic          a_vld_reg;
    logic [NW-1:0] a_dx_reg;
    logic [NW-1:0] a_dy_reg;

    // Stage B: folded magnitudes
    logic          b_vld_reg;
    logic [NW-1:0] b_ax_reg;
    logic [NW-1:0] b_ay_reg;
    logic          b_sx_reg;
    logic          b_sy_reg;
    logic          b_zero_reg;
    logic [NW-1:0] b_ax_next;
    logic [NW-1:0] b_ay_next;

    // Stage C: numerator / denominator selection
    logic          c_vld_reg;
    logic [NW-1:0] c_num3_reg;
    logic [DW-1:0] c_den_reg;
    logic          c_small_reg;
    logic          c_zero_reg;
    logic [2:0]    c_oct_reg;
    logic          c_gt_next;
    logic [NW-1:0] c_num_next;
    logic [NW-1:0] c_den_full_next;

    // Divider pipe: index 0 is the saturation stage, index QW the last step
    logic             dv_vld_reg  [0:QW];
    logic [NW-1:0]    dv_rem_reg  [0:QW];
    logic [DW-1:0]    dv_den_reg  [0:QW];
    logic [QW-1:0]    dv_quo_reg  [0:QW];
    ptba_pkg::meta_t  dv_meta_reg [0:QW];
    logic [NW-1:0]    dv_rem_next [1:QW];
    logic [QW-1:0]    dv_quo_next [1:QW];
    logic             d_sat_next;

    // Stage F: ROM read
    logic             f_vld_reg;
    ptba_pkg::meta_t  f_meta_reg;
    ptba_pkg::angle_t f_rom_reg;
    logic [IW-1:0]    f_idx_next;

    // Stage G: octant offset
    logic             g_vld_reg;
    ptba_pkg::angle_t g_angle_reg;
    ptba_pkg::angle_t g_angle_next;

    // Fully pipelined: every cycle takes a beat
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Fold each component into a magnitude, keep the sign
    always_comb
    begin
        b_ax_next = a_dx_reg[NW-1] ? (NW'(0) - a_dx_reg) : a_dx_reg;
        b_ay_next = a_dy_reg[NW-1] ? (NW'(0) - a_dy_reg) : a_dy_reg;
    end

    // Pick the flatter component as numerator
    always_comb
    begin
        c_gt_next       = $signed(b_ax_reg) > $signed(b_ay_reg);
        c_num_next      = c_gt_next ? b_ay_reg : b_ax_reg;
        c_den_full_next = c_gt_next ? b_ax_reg : b_ay_reg;
    end

    // Saturate when the quotient would reach the table end
    assign d_sat_next = CW'(c_num3_reg) >= (CW'(c_den_reg) * CW'(ptba_pkg::SLOPE_RANGE));

    // One restoring quotient bit per stage, most significant first
    always_comb
    begin
        for (int s = 0; s < QW; s++) begin
            logic [CW-1:0] trial;
            trial = CW'(dv_den_reg[s]) << (QW - 1 - s);
            dv_rem_next[s+1] = dv_rem_reg[s];
            dv_quo_next[s+1] = dv_quo_reg[s];
            if (CW'(dv_rem_reg[s]) >= trial) begin
                dv_rem_next[s+1] = dv_rem_reg[s] - trial[NW-1:0];
                dv_quo_next[s+1][QW-1-s] = 1'b1;
            end
        end
    end

    // Table index: force the last entry on saturation or small denominator
    assign f_idx_next = dv_meta_reg[QW].force_max ? IW'(ptba_pkg::SLOPE_RANGE)
                                                  : IW'(dv_quo_reg[QW]);

    // Mirror and offset the first-octant angle
    always_comb
    begin
        case (f_meta_reg.oct)
            ptba_pkg::OCT_PX_PY_XWIDE:  g_angle_next = f_rom_reg;
            ptba_pkg::OCT_PX_PY_YSTEEP: g_angle_next = ptba_pkg::ANG90 - 32'd1 - f_rom_reg;
            ptba_pkg::OCT_PX_NY_XWIDE:  g_angle_next = 32'd0 - f_rom_reg;
            ptba_pkg::OCT_PX_NY_YSTEEP: g_angle_next = ptba_pkg::ANG270 + f_rom_reg;
            ptba_pkg::OCT_NX_PY_XWIDE:  g_angle_next = ptba_pkg::ANG180 - 32'd1 - f_rom_reg;
            ptba_pkg::OCT_NX_PY_YSTEEP: g_angle_next = ptba_pkg::ANG90 + f_rom_reg;
            ptba_pkg::OCT_NX_NY_XWIDE:  g_angle_next = ptba_pkg::ANG180 + f_rom_reg;
            ptba_pkg::OCT_NX_NY_YSTEEP: g_angle_next = ptba_pkg::ANG270 - 32'd1 - f_rom_reg;
            default:                    g_angle_next = f_rom_reg;
        endcase
        if (f_meta_reg.zero) begin
            g_angle_next = '0;
        end
    end

    // Advance the stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            for (int s = 0; s <= QW; s++) begin
                dv_vld_reg[s] <= 1'b0;
            end
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
        end else begin
            a_vld_reg     <= accept;
            b_vld_reg     <= a_vld_reg;
            c_vld_reg     <= b_vld_reg;
            dv_vld_reg[0] <= c_vld_reg;
            for (int s = 1; s <= QW; s++) begin
                dv_vld_reg[s] <= dv_vld_reg[s-1];
            end
            f_vld_reg <= dv_vld_reg[QW];
            g_vld_reg <= f_vld_reg;
        end
    end

    // Advance the payload through the front stages
    always_ff @(posedge clk)
    begin
        a_dx_reg <= NW'(to_x) - NW'(from_x);
        a_dy_reg <= NW'(to_y) - NW'(from_y);

        b_ax_reg   <= b_ax_next;
        b_ay_reg   <= b_ay_next;
        b_sx_reg   <= a_dx_reg[NW-1];
        b_sy_reg   <= a_dy_reg[NW-1];
        b_zero_reg <= (a_dx_reg == '0) && (a_dy_reg == '0);

        c_num3_reg  <= c_num_next << ptba_pkg::NUM_SHIFT;
        c_den_reg   <= c_den_full_next[NW-1:ptba_pkg::DEN_SHIFT];
        c_small_reg <= c_den_full_next < NW'(ptba_pkg::SMALL_DEN);
        c_zero_reg  <= b_zero_reg;
        c_oct_reg   <= {b_sx_reg, b_sy_reg, c_gt_next};
    end

    // Advance the divider pipe
    always_ff @(posedge clk)
    begin
        dv_rem_reg[0]            <= c_num3_reg;
        dv_den_reg[0]            <= c_den_reg;
        dv_quo_reg[0]            <= '0;
        dv_meta_reg[0].zero      <= c_zero_reg;
        dv_meta_reg[0].oct       <= c_oct_reg;
        dv_meta_reg[0].force_max <= c_small_reg || d_sat_next;
        for (int s = 1; s <= QW; s++) begin
            dv_rem_reg[s]  <= dv_rem_next[s];
            dv_quo_reg[s]  <= dv_quo_next[s];
            dv_den_reg[s]  <= dv_den_reg[s-1];
            dv_meta_reg[s] <= dv_meta_reg[s-1];
        end
    end

    // Read the arctangent ROM, then apply the octant offset
    always_ff @(posedge clk)
    begin
        f_rom_reg   <= ATAN_ROM[f_idx_next];
        f_meta_reg  <= dv_meta_reg[QW];
        g_angle_reg <= g_angle_next;
    end

    assign done  = g_vld_reg;
    assign angle = g_angle_reg;

endmodule

[rtl/core/ptba_checker.sv]
// ----------------------------------------------------------------------------
// ptba_checker
// Port-level timing and value checks for the point-to-angle unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptba_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic signed [ptba_pkg::COORD_W-1:0] from_x,
    input logic signed [ptba_pkg::COORD_W-1:0] from_y,
    input logic signed [ptba_pkg::COORD_W-1:0] to_x,
    input logic signed [ptba_pkg::COORD_W-1:0] to_y,
    input logic        done,
    input logic [ptba_pkg::ANGLE_W-1:0] angle
);

    logic [ptba_pkg::COORD_W-1:0] dx;
    logic beat;
    logic same_point;
    logic flat_east;

    assign beat = start && !busy;
    assign dx   = ptba_pkg::COORD_W'(to_x) - ptba_pkg::COORD_W'(from_x);

    // Both points coincide
    assign same_point = (to_x == from_x) && (to_y == from_y);

    // Positive x axis with a wide enough span reads table entry zero
    assign flat_east = (to_y == from_y) && !dx[ptba_pkg::COORD_W-1]
                       && (dx >= ptba_pkg::COORD_W'(ptba_pkg::SMALL_DEN));

    // Every beat yields a strobe after the fixed latency
    `PTBA_ASSERT_DELAY(a_beat_done, clk, rst_n, beat, ptba_pkg::LATENCY, done)

    // No strobe without a beat that latency ago
    `PTBA_ASSERT_IMPLY(a_done_src, clk, rst_n, done, $past(beat, ptba_pkg::LATENCY))

    // Coincident points give angle zero
    `PTBA_ASSERT_DELAY(a_zero_vec, clk, rst_n, beat && same_point, ptba_pkg::LATENCY, angle == '0)

    // Due east gives angle zero
    `PTBA_ASSERT_DELAY(a_east, clk, rst_n, beat && flat_east, ptba_pkg::LATENCY, angle == '0)

endmodule

bind point_to_binary_angle_unit ptba_checker u_ptba_checker (.*);

[tb/sv/ptba_angle_checker.sv]
// ----------------------------------------------------------------------------
// ptba_angle_checker
// Watches the point and angle ports of the point-to-angle unit. Predicts the
// angle of every accepted beat from its own arctangent table and octant fold,
// and compares each done strobe against the oldest prediction in order.
// ----------------------------------------------------------------------------
module ptba_angle_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [ptba_pkg::COORD_W-1:0] from_x,
    input  logic [ptba_pkg::COORD_W-1:0] from_y,
    input  logic [ptba_pkg::COORD_W-1:0] to_x,
    input  logic [ptba_pkg::COORD_W-1:0] to_y,
    input  logic        done,
    input  logic [ptba_pkg::ANGLE_W-1:0] angle,
    output int          mismatches,
    output int          angles_checked,
    output int          angles_pending,
    output bit [10:0]   cases_hit
);
    timeunit 1ns;
    timeprecision 1ps;

    // Class bits beyond the eight octants
    localparam int HIT_ZERO      = 8;
    localparam int HIT_MOST_NEG  = 9;
    localparam int HIT_SMALL_DEN = 10;

    localparam int ROT_STEPS = 32;
    localparam int ROT_FRAC  = 40;

    // atan(2^-k) scaled to 2^32 per turn
    localparam ptba_pkg::angle_t ROT_ANGLE [0:ROT_STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    ptba_pkg::angle_t atan_lut [0:ptba_pkg::SLOPE_RANGE];
    ptba_pkg::angle_t expected_angles [$];
    ptba_pkg::angle_t want;
    bit [10:0]        beat_hit;

    // Shift right, rounding toward zero for negative values
    function automatic longint trunc_shift(longint v, int k);
        return (v < 0) ? -((-v) >>> k) : (v >>> k);
    endfunction

    // Vectoring rotation for atan(i / SLOPE_RANGE), clamped to one octant
    function automatic ptba_pkg::angle_t rotate_to_axis(int i);
        longint px;
        longint py;
        longint sx;
        longint sy;
        ptba_pkg::angle_t acc;
        px  = longint'(ptba_pkg::SLOPE_RANGE) <<< ROT_FRAC;
        py  = longint'(i) <<< ROT_FRAC;
        acc = '0;
        for (int k = 0; k < ROT_STEPS && py != 0; k++) begin
            sx = trunc_shift(px, k);
            sy = trunc_shift(py, k);
            if (py > 0) begin
                px  = px + sy;
                py  = py - sx;
                acc = acc + ROT_ANGLE[k];
            end else begin
                px  = px - sy;
                py  = py + sx;
                acc = acc - ROT_ANGLE[k];
            end
        end
        if (acc[ptba_pkg::ANGLE_W-1]) begin
            return '0;
        end
        if (acc > ptba_pkg::ANG_CLAMP) begin
            return ptba_pkg::ANG_CLAMP;
        end
        return acc;
    endfunction

    // Saturating slope divide followed by the table read
    function automatic ptba_pkg::angle_t slope_atan(logic [31:0] num, logic [31:0] den);
        logic [31:0] scaled;
        logic [31:0] quo;
        if (den < ptba_pkg::SMALL_DEN) begin
            return atan_lut[ptba_pkg::SLOPE_RANGE];
        end
        scaled = num << ptba_pkg::NUM_SHIFT;
        quo    = scaled / (den >> ptba_pkg::DEN_SHIFT);
        if (quo > ptba_pkg::SLOPE_RANGE) begin
            quo = ptba_pkg::SLOPE_RANGE;
        end
        return atan_lut[quo[ptba_pkg::IDX_W-1:0]];
    endfunction

    // Fold the vector into the first octant, look up, and unfold
    function automatic ptba_pkg::angle_t predict_angle(
        input  logic [31:0] fx,
        input  logic [31:0] fy,
        input  logic [31:0] tx,
        input  logic [31:0] ty,
        output bit [10:0]   hit
    );
        logic [31:0] dx;
        logic [31:0] dy;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] num;
        logic [31:0] den;
        logic [2:0]  oct;
        ptba_pkg::angle_t lut;
        hit = '0;
        dx  = tx - fx;
        dy  = ty - fy;
        if (dx == 32'h8000_0000 || dy == 32'h8000_0000) begin
            hit[HIT_MOST_NEG] = 1'b1;
        end
        if (dx == '0 && dy == '0) begin
            hit[HIT_ZERO] = 1'b1;
            return '0;
        end
        ax  = dx[31] ? 32'd0 - dx : dx;
        ay  = dy[31] ? 32'd0 - dy : dy;
        oct = {dx[31], dy[31], $signed(ax) > $signed(ay)};
        num = oct[0] ? ay : ax;
        den = oct[0] ? ax : ay;
        hit[oct] = 1'b1;
        if (den < ptba_pkg::SMALL_DEN) begin
            hit[HIT_SMALL_DEN] = 1'b1;
        end
        lut = slope_atan(num, den);
        case (oct)
            ptba_pkg::OCT_PX_PY_XWIDE:  return lut;
            ptba_pkg::OCT_PX_PY_YSTEEP: return ptba_pkg::ANG90 - 1 - lut;
            ptba_pkg::OCT_PX_NY_XWIDE:  return 32'd0 - lut;
            ptba_pkg::OCT_PX_NY_YSTEEP: return ptba_pkg::ANG270 + lut;
            ptba_pkg::OCT_NX_PY_XWIDE:  return ptba_pkg::ANG180 - 1 - lut;
            ptba_pkg::OCT_NX_PY_YSTEEP: return ptba_pkg::ANG90 + lut;
            ptba_pkg::OCT_NX_NY_XWIDE:  return ptba_pkg::ANG180 + lut;
            default:                    return ptba_pkg::ANG270 - 1 - lut;
        endcase
    endfunction

    // Build the arctangent table once
    initial
    begin
        for (int i = 0; i <= ptba_pkg::SLOPE_RANGE; i++) begin
            atan_lut[i] = rotate_to_axis(i);
        end
    end

    // Check results first, then queue the prediction for a new beat
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done) begin
                if (expected_angles.size() == 0) begin
                    $display("%0t: angle %h arrived with no beat outstanding", $time, angle);
                    mismatches++;
                end else begin
                    want = expected_angles.pop_front();
                    angles_checked++;
                    if (angle !== want) begin
                        $display("%0t: angle mismatch, expected %h, actual %h",
                                 $time, want, angle);
                        mismatches++;
                    end
                end
            end
            if (start && !busy) begin
                expected_angles.push_back(predict_angle(from_x, from_y, to_x, to_y,
                                                        beat_hit));
                cases_hit |= beat_hit;
            end
            angles_pending = expected_angles.size();
        end
    end

endmodule

[tb/sv/point_to_binary_angle_unit_test.sv]
// ----------------------------------------------------------------------------
// point_to_binary_angle_unit_test
// Drives point pairs into the point-to-angle unit: a directed set of
// octants, axes and wrap cases, then random vectors from tiny to full range
// in random bursts. The checker beside the block predicts every angle.
// ----------------------------------------------------------------------------
module point_to_binary_angle_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 930;
    localparam int IDLE_LIMIT   = 1000;

    logic        clk    = 1'b0;
    logic        rst_n  = 1'b0;
    logic        start  = 1'b0;
    logic [31:0] from_x = '0;
    logic [31:0] from_y = '0;
    logic [31:0] to_x   = '0;
    logic [31:0] to_y   = '0;
    logic        busy;
    logic        done;
    logic [31:0] angle;

    int          mismatches;
    int          angles_checked;
    int          angles_pending;
    bit [10:0]   cases_hit;
    int          beats_sent;
    int          directed_beats;
    int          burst_left;
    int          idle_cycles;

    point_to_binary_angle_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .from_x (from_x),
        .from_y (from_y),
        .to_x   (to_x),
        .to_y   (to_y),
        .done   (done),
        .angle  (angle)
    );

    ptba_angle_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .from_x         (from_x),
        .from_y         (from_y),
        .to_x           (to_x),
        .to_y           (to_y),
        .done           (done),
        .angle          (angle),
        .mismatches     (mismatches),
        .angles_checked (angles_checked),
        .angles_pending (angles_pending),
        .cases_hit      (cases_hit)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort when neither side moves a beat for too long
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((start && !busy) || done) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("point_to_binary_angle_unit verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Present one beat and hold it until taken
    task automatic send_point(input logic [31:0] fx, input logic [31:0] fy,
                              input logic [31:0] tx, input logic [31:0] ty);
        start  <= 1'b1;
        from_x <= fx;
        from_y <= fy;
        to_x   <= tx;
        to_y   <= ty;
        @(posedge clk);
        while (busy) @(posedge clk);
        beats_sent++;
    endtask

    // Send a difference vector from a random origin
    task automatic send_delta(input logic [31:0] dx, input logic [31:0] dy);
        logic [31:0] fx;
        logic [31:0] fy;
        fx = $urandom;
        fy = $urandom;
        send_point(fx, fy, fx + dx, fy + dy);
    endtask

    // Drop start and hold until every angle is back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (angles_pending != 0) @(posedge clk);
        burst_left = 0;
    endtask

    // Open a new burst after a random gap when the current one runs out
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 5);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Random magnitude over all scales, random sign
    function automatic logic [31:0] rand_span();
        logic [31:0] m;
        m = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) begin
            m = 32'd0 - m;
        end
        return m;
    endfunction

    // One random beat, weighted toward tricky vectors
    task automatic random_point();
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] v;
        logic [31:0] w;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: send_point($urandom, $urandom, $urandom, $urandom);
            6, 7, 8, 9, 10:   send_delta(rand_span(), rand_span());
            11, 12, 13: begin
                // tiny vectors around the small denominator bound
                d = $urandom_range(0, 1400) - 700;
                e = $urandom_range(0, 1400) - 700;
                send_delta(d, e);
            end
            14, 15: begin
                // near the diagonal
                d = rand_span();
                e = ($urandom_range(0, 1) ? d : 32'd0 - d) + $urandom_range(0, 8) - 4;
                send_delta(d, e);
            end
            16, 17: begin
                // axis or most negative component
                d = $urandom_range(0, 1) ? 32'h8000_0000 : 32'd0;
                e = rand_span();
                if ($urandom_range(0, 1)) send_delta(d, e);
                else send_delta(e, d);
            end
            18: begin
                // slope saturation: one component far larger
                d = rand_span();
                e = $signed(rand_span()) >>> $urandom_range(4, 20);
                send_delta(d, e);
            end
            default: begin
                v = $urandom;
                w = $urandom;
                send_point(v, w, v, w);
            end
        endcase
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero vectors, axes, eight octants, diagonals, wrap cases
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h0, 32'h0, 32'h0, 32'h0);
        send_delta(32'd1, 32'd0);
        send_delta(32'd0, 32'd1);
        send_delta(32'hFFFF_FFFF, 32'd0);
        send_delta(32'd0, 32'hFFFF_FFFF);
        send_delta(32'd3_000_000, 32'd1_000_000);
        send_delta(32'd1_000_000, 32'd3_000_000);
        send_delta(32'd3_000_000, -32'd1_000_000);
        send_delta(32'd1_000_000, -32'd3_000_000);
        send_delta(-32'd3_000_000, 32'd1_000_000);
        send_delta(-32'd1_000_000, 32'd3_000_000);
        send_delta(-32'd3_000_000, -32'd1_000_000);
        send_delta(-32'd1_000_000, -32'd3_000_000);
        send_delta(32'd65536, 32'd65536);
        send_delta(-32'd65536, -32'd65536);
        send_delta(32'h8000_0000, 32'd5);
        send_delta(32'd7, 32'h8000_0000);
        send_delta(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_delta(32'h7FFF_FFFF, 32'h3FFF_FFFF);
        send_delta(32'd512, 32'd100);
        send_delta(32'd511, 32'd300);
        directed_beats = beats_sent;
        drain();

        // Random bursts, with one full drain midway
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pace();
            random_point();
            if (n == RANDOM_ITEMS / 2) begin
                drain();
            end
        end
        drain();
        repeat (ptba_pkg::LATENCY + 4) @(posedge clk);

        $display("Sent %0d point pairs (%0d directed), compared %0d angles",
                 beats_sent, directed_beats, angles_checked);
        $display("Octant, zero, most-negative and small-divisor classes reached: %0d of 11",
                 $countones(cases_hit));
        if (mismatches == 0) begin
            $display("point_to_binary_angle_unit verification clean");
        end else begin
            $display("point_to_binary_angle_unit verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ptba_pkg.sv
rtl/core/point_to_binary_angle_unit.sv
rtl/core/ptba_checker.sv
tb/sv/ptba_angle_checker.sv
tb/sv/point_to_binary_angle_unit_test.sv
